// ----- sv/bsom_pkg.sv -----
// shared types and codes for the buy/sell order matcher
// used by bsom_ctrl, bsom_dp and buy_sell_order_matcher_core; no dependencies
package bsom_pkg;

  // default table depths and symbol length
  localparam int BUY_DEPTH_DEF    = 16;
  localparam int SELL_DEPTH_DEF   = 16;
  localparam int SYMBOL_CHARS_DEF = 8;

  // fixed field widths
  localparam int KIND_W   = 2;
  localparam int SYMIN_W  = 64;
  localparam int QTY_W    = 16;
  localparam int PRICE_W  = 24;
  localparam int STAT_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int SUM_W    = 25;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_BUY   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SELL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MATCH = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ACCEPT = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_TRADE  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE   = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load_buy;   // append buy offer
    logic load_sell;  // append sell offer
    logic start;      // set up walk indices, clear pending trade
    logic rd_pair;    // read buy[b] and sell[s]
    logic rd_sell;    // read sell[s]
    logic take_buy;   // latch remaining buy quantity
    logic commit;     // apply compare result of current pair
    logic advance;    // step to next pair
    logic finish;     // emit final result of a match run
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic any_empty;
    logic match;
    logic pend_valid;
    logic s_zero;
    logic b_zero;
    logic out_free;
  } stat_t;

endpackage

// ----- sv/buy_sell_order_matcher_core.sv -----
// load item: result registered at acceptance and valid in the next cycle, one item per cycle while unstalled
// match item: steps S_RDBUY, S_LDBUY, S_CMP for each buy and S_RDSELL, S_CMP for each further sell,
//   waits while the result port stalls, and goes straight to S_FINAL when either table is empty;
//   a read state comes before each compare, set by the registered read port of the sell table
// no new item is taken while a match run walks the tables
// sync reset clears both offer counts, the controller and the result valid; table contents
//   are left as they are and only entries below the counts are ever read
module buy_sell_order_matcher_core #(
  parameter int BUY_DEPTH    = bsom_pkg::BUY_DEPTH_DEF,
  parameter int SELL_DEPTH   = bsom_pkg::SELL_DEPTH_DEF,
  parameter int SYMBOL_CHARS = bsom_pkg::SYMBOL_CHARS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input item channel
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [bsom_pkg::KIND_W-1:0]  kind,
  input  logic [bsom_pkg::SYMIN_W-1:0] symbol,
  input  logic [bsom_pkg::QTY_W-1:0]   quantity,
  input  logic [bsom_pkg::PRICE_W-1:0] price_cents,
  // result item channel
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [bsom_pkg::STAT_W-1:0]  status,
  output logic [bsom_pkg::SLOT_W-1:0]  buy_slot,
  output logic [bsom_pkg::SLOT_W-1:0]  sell_slot,
  output logic [bsom_pkg::QTY_W-1:0]   traded_quantity,
  output logic [bsom_pkg::SUM_W-1:0]   price_sum,
  output logic                         last
);
  import bsom_pkg::*;

  // command and status between controller and datapath
  cmd_t  cmd;
  stat_t stat;

  // controller: idle/load handling, then the newest-first walk over buys and sells
  bsom_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .kind      (kind),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: offer tables, compare and trade math, pending trade and result register
  // a found trade waits in a pending register so the last flag can go on the final one
  bsom_dp #(
    .BUY_DEPTH    (BUY_DEPTH),
    .SELL_DEPTH   (SELL_DEPTH),
    .SYMBOL_CHARS (SYMBOL_CHARS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .symbol          (symbol),
    .quantity        (quantity),
    .price_cents     (price_cents),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .status          (status),
    .buy_slot        (buy_slot),
    .sell_slot       (sell_slot),
    .traded_quantity (traded_quantity),
    .price_sum       (price_sum),
    .last            (last)
  );

  // a trade result always carries a nonzero quantity
  a_trade_qty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_TRADE) |-> (traded_quantity != '0))
    else $error("trade with zero quantity");

  // load results and the no-trade result of a match run are single results
  a_load_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status == ST_ACCEPT || status == ST_FULL || status == ST_NONE)) |-> last)
    else $error("single result without last flag");

  // while a result is pending on the port, no input item is taken
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |-> cmd_stall)
    else $error("input taken while result stalled");

endmodule

// ----- sv/bsom_ctrl.sv -----
// controller state machine for the order matcher
// depends on bsom_pkg (cmd_t, stat_t, kind codes)
module bsom_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic [bsom_pkg::KIND_W-1:0] kind,
  input  bsom_pkg::stat_t            stat,
  output bsom_pkg::cmd_t             cmd
);
  import bsom_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDBUY  = 3'd1;
  localparam logic [2:0] S_LDBUY  = 3'd2;
  localparam logic [2:0] S_RDSELL = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_FINAL  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       hold;

  assign cmd_stall = !((state == S_IDLE) && stat.out_free);
  assign accept    = cmd_valid && !cmd_stall;
  // a new trade needs the pending one moved to the output first
  assign hold      = stat.match && stat.pend_valid && !stat.out_free;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (kind == KIND_BUY) begin
            cmd.load_buy = 1'b1;
          end else if (kind == KIND_SELL) begin
            cmd.load_sell = 1'b1;
          end else if (kind == KIND_MATCH) begin
            cmd.start  = 1'b1;
            state_next = stat.any_empty ? S_FINAL : S_RDBUY;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_RDBUY: begin
        cmd.rd_pair = 1'b1;
        state_next  = S_LDBUY;
      end
      S_LDBUY: begin
        cmd.take_buy = 1'b1;
        state_next   = S_CMP;
      end
      S_RDSELL: begin
        cmd.rd_sell = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        if (!hold) begin
          cmd.commit  = 1'b1;
          cmd.advance = 1'b1;
          priority if (!stat.s_zero) begin
            state_next = S_RDSELL;
          end else if (!stat.b_zero) begin
            state_next = S_RDBUY;
          end else begin
            state_next = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_stall_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> cmd_stall)
    else $error("input taken while a match run is active");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == S_RDBUY || state == S_FINAL))
    else $error("match run did not start");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == S_IDLE))
    else $error("controller did not return to idle after final result");

endmodule

// ----- sv/bsom_dp.sv -----
// datapath for the order matcher: offer tables, walk indices, compare, result regs
// depends on bsom_pkg (cmd_t, stat_t, widths, status codes)
module bsom_dp #(
  parameter int BUY_DEPTH    = bsom_pkg::BUY_DEPTH_DEF,
  parameter int SELL_DEPTH   = bsom_pkg::SELL_DEPTH_DEF,
  parameter int SYMBOL_CHARS = bsom_pkg::SYMBOL_CHARS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bsom_pkg::cmd_t               cmd,
  output bsom_pkg::stat_t              stat,
  input  logic [bsom_pkg::SYMIN_W-1:0] symbol,
  input  logic [bsom_pkg::QTY_W-1:0]   quantity,
  input  logic [bsom_pkg::PRICE_W-1:0] price_cents,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [bsom_pkg::STAT_W-1:0]  status,
  output logic [bsom_pkg::SLOT_W-1:0]  buy_slot,
  output logic [bsom_pkg::SLOT_W-1:0]  sell_slot,
  output logic [bsom_pkg::QTY_W-1:0]   traded_quantity,
  output logic [bsom_pkg::SUM_W-1:0]   price_sum,
  output logic                         last
);
  import bsom_pkg::*;

  localparam int SYM_W = 8 * SYMBOL_CHARS;
  localparam int BAW   = (BUY_DEPTH > 1) ? $clog2(BUY_DEPTH) : 1;
  localparam int SAW   = (SELL_DEPTH > 1) ? $clog2(SELL_DEPTH) : 1;
  localparam int BCW   = $clog2(BUY_DEPTH + 1);
  localparam int SCW   = $clog2(SELL_DEPTH + 1);

  // offer tables
  logic [SYM_W-1:0]   buy_sym  [BUY_DEPTH];
  logic [PRICE_W-1:0] buy_prc  [BUY_DEPTH];
  logic [QTY_W-1:0]   buy_qty  [BUY_DEPTH];
  logic [SYM_W-1:0]   sell_sym [SELL_DEPTH];
  logic [PRICE_W-1:0] sell_prc [SELL_DEPTH];
  logic [QTY_W-1:0]   sell_qty [SELL_DEPTH];

  logic [SYM_W-1:0]   buy_rd_sym;
  logic [PRICE_W-1:0] buy_rd_prc;
  logic [QTY_W-1:0]   buy_rd_qty;
  logic [SYM_W-1:0]   sell_rd_sym;
  logic [PRICE_W-1:0] sell_rd_prc;
  logic [QTY_W-1:0]   sell_rd_qty;

  logic [BCW-1:0] buy_count;
  logic [SCW-1:0] sell_count;
  logic [BAW-1:0] b;
  logic [SAW-1:0] s;
  logic [QTY_W-1:0] bq;

  // pending trade, held until the next one or the end shows whether it is last
  logic              pend_valid;
  logic [SLOT_W-1:0] pend_b;
  logic [SLOT_W-1:0] pend_s;
  logic [QTY_W-1:0]  pend_q;
  logic [SUM_W-1:0]  pend_sum;

  logic             buy_full;
  logic             sell_full;
  logic             match;
  logic [QTY_W-1:0] q;
  logic [QTY_W-1:0] bq_after;
  logic [SUM_W-1:0] sum;
  logic             out_free;
  logic             push_pend;

  assign buy_full  = (buy_count == BCW'(BUY_DEPTH));
  assign sell_full = (sell_count == SCW'(SELL_DEPTH));
  assign match     = (buy_rd_sym == sell_rd_sym) && (bq != '0) && (sell_rd_qty != '0)
                     && (buy_rd_prc >= sell_rd_prc);
  assign q         = (bq < sell_rd_qty) ? bq : sell_rd_qty;
  assign bq_after  = match ? (bq - q) : bq;
  assign sum       = {1'b0, buy_rd_prc} + {1'b0, sell_rd_prc};
  assign out_free  = !res_valid || !res_stall;
  assign push_pend = cmd.commit && match && pend_valid;

  assign stat.any_empty  = (buy_count == '0) || (sell_count == '0);
  assign stat.match      = match;
  assign stat.pend_valid = pend_valid;
  assign stat.s_zero     = (s == '0);
  assign stat.b_zero     = (b == '0);
  assign stat.out_free   = out_free;

  // buy table
  always_ff @(posedge clk) begin
    if (cmd.load_buy && !buy_full) begin
      buy_sym[buy_count[BAW-1:0]] <= symbol[SYM_W-1:0];
      buy_prc[buy_count[BAW-1:0]] <= price_cents;
    end
    if (cmd.load_buy && !buy_full) begin
      buy_qty[buy_count[BAW-1:0]] <= quantity;
    end else if (cmd.commit && stat.s_zero) begin
      buy_qty[b] <= bq_after;
    end
    if (cmd.rd_pair) begin
      buy_rd_sym <= buy_sym[b];
      buy_rd_prc <= buy_prc[b];
      buy_rd_qty <= buy_qty[b];
    end
  end

  // sell table
  always_ff @(posedge clk) begin
    if (cmd.load_sell && !sell_full) begin
      sell_sym[sell_count[SAW-1:0]] <= symbol[SYM_W-1:0];
      sell_prc[sell_count[SAW-1:0]] <= price_cents;
    end
    if (cmd.load_sell && !sell_full) begin
      sell_qty[sell_count[SAW-1:0]] <= quantity;
    end else if (cmd.commit && match) begin
      sell_qty[s] <= sell_rd_qty - q;
    end
    if (cmd.rd_pair || cmd.rd_sell) begin
      sell_rd_sym <= sell_sym[s];
      sell_rd_prc <= sell_prc[s];
      sell_rd_qty <= sell_qty[s];
    end
  end

  // counts, walk indices, pending trade flag
  always_ff @(posedge clk) begin
    if (rst) begin
      buy_count  <= '0;
      sell_count <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.load_buy && !buy_full) begin
        buy_count <= buy_count + BCW'(1);
      end
      if (cmd.load_sell && !sell_full) begin
        sell_count <= sell_count + SCW'(1);
      end
      if (cmd.start) begin
        pend_valid <= 1'b0;
      end else if (cmd.commit && match) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      b <= BAW'(buy_count - BCW'(1));
      s <= SAW'(sell_count - SCW'(1));
    end else if (cmd.advance) begin
      if (!stat.s_zero) begin
        s <= s - SAW'(1);
      end else begin
        b <= b - BAW'(1);
        s <= SAW'(sell_count - SCW'(1));
      end
    end
    if (cmd.take_buy) begin
      bq <= buy_rd_qty;
    end else if (cmd.commit) begin
      bq <= bq_after;
    end
    if (cmd.commit && match) begin
      pend_b   <= SLOT_W'(b);
      pend_s   <= SLOT_W'(s);
      pend_q   <= q;
      pend_sum <= sum;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_buy || cmd.load_sell || cmd.finish || push_pend) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load_buy || cmd.load_sell) begin
      status          <= (cmd.load_buy ? buy_full : sell_full) ? ST_FULL : ST_ACCEPT;
      buy_slot        <= '0;
      sell_slot       <= '0;
      traded_quantity <= '0;
      price_sum       <= '0;
      last            <= 1'b1;
    end else if (push_pend || (cmd.finish && pend_valid)) begin
      status          <= ST_TRADE;
      buy_slot        <= pend_b;
      sell_slot       <= pend_s;
      traded_quantity <= pend_q;
      price_sum       <= pend_sum;
      last            <= cmd.finish;
    end else if (cmd.finish) begin
      status          <= ST_NONE;
      buy_slot        <= '0;
      sell_slot       <= '0;
      traded_quantity <= '0;
      price_sum       <= '0;
      last            <= 1'b1;
    end else begin
      // nothing new, result fields hold
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_buy || cmd.load_sell || cmd.finish || push_pend) |-> out_free)
    else $error("result register overwritten while stalled");

  a_buy_count_range: assert property (@(posedge clk) disable iff (rst)
    buy_count <= BCW'(BUY_DEPTH))
    else $error("buy count beyond table depth");

  a_sell_count_range: assert property (@(posedge clk) disable iff (rst)
    sell_count <= SCW'(SELL_DEPTH))
    else $error("sell count beyond table depth");

  a_trade_sets_pend: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && match && !cmd.start) |=> pend_valid)
    else $error("trade not kept as pending");

endmodule

// ----- tb/bsom_tb_pkg.sv -----
`timescale 1ns / 100ps
// order book tracker for the buy/sell order matcher testbench: predicts and checks results
// depends on bsom_pkg for field widths, kinds, status codes and default table depths
package bsom_tb_pkg;
  import bsom_pkg::*;

  // kind code that the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // only the low SYMBOL_CHARS bytes of a symbol take part in a compare
  localparam logic [SYMIN_W-1:0] SYM_MASK = (SYMBOL_CHARS_DEF >= 8) ? '1 :
    ((64'd1 << (8 * SYMBOL_CHARS_DEF)) - 64'd1);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] buy_slot;
    logic [SLOT_W-1:0] sell_slot;
    logic [QTY_W-1:0]  qty;
    logic [SUM_W-1:0]  psum;
    logic              last;
  } book_result_t;

  class order_book_tracker;
    logic [SYMIN_W-1:0] buy_sym    [BUY_DEPTH_DEF];
    logic [QTY_W-1:0]   buy_qty    [BUY_DEPTH_DEF];
    logic [PRICE_W-1:0] buy_price  [BUY_DEPTH_DEF];
    int                 buy_count;
    logic [SYMIN_W-1:0] sell_sym   [SELL_DEPTH_DEF];
    logic [QTY_W-1:0]   sell_qty   [SELL_DEPTH_DEF];
    logic [PRICE_W-1:0] sell_price [SELL_DEPTH_DEF];
    int                 sell_count;
    book_result_t       due_q[$];
    int                 errors;
    int                 seen;

    function new();
      buy_count  = 0;
      sell_count = 0;
      errors     = 0;
      seen       = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // single result of a load or of a match run without trades
    function book_result_t lone_result(logic [STAT_W-1:0] st);
      book_result_t r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      return r;
    endfunction

    // buys newest first, and for each buy the sells newest first
    function void walk_book();
      int               b;
      int               s;
      logic [QTY_W-1:0] q;
      book_result_t     held;
      bit               have_held;
      have_held = 1'b0;
      held      = '0;
      for (b = buy_count - 1; b >= 0; b--) begin
        for (s = sell_count - 1; s >= 0; s--) begin
          if (buy_sym[b] == sell_sym[s] && buy_qty[b] != '0 && sell_qty[s] != '0 &&
              buy_price[b] >= sell_price[s]) begin
            q = (buy_qty[b] < sell_qty[s]) ? buy_qty[b] : sell_qty[s];
            buy_qty[b]  -= q;
            sell_qty[s] -= q;
            if (have_held) due_q.push_back(held);
            held.status    = ST_TRADE;
            held.buy_slot  = SLOT_W'(b);
            held.sell_slot = SLOT_W'(s);
            held.qty       = q;
            held.psum      = {1'b0, buy_price[b]} + {1'b0, sell_price[s]};
            held.last      = 1'b0;
            have_held      = 1'b1;
          end
        end
      end
      if (!have_held) begin
        due_q.push_back(lone_result(ST_NONE));
      end else begin
        held.last = 1'b1;
        due_q.push_back(held);
      end
    endfunction

    // called for every accepted input item
    function void apply_item(logic [KIND_W-1:0] k, logic [SYMIN_W-1:0] sym,
                             logic [QTY_W-1:0] q, logic [PRICE_W-1:0] p);
      case (k)
        KIND_BUY: begin
          if (buy_count >= BUY_DEPTH_DEF) begin
            due_q.push_back(lone_result(ST_FULL));
          end else begin
            buy_sym[buy_count]   = sym & SYM_MASK;
            buy_qty[buy_count]   = q;
            buy_price[buy_count] = p;
            buy_count++;
            due_q.push_back(lone_result(ST_ACCEPT));
          end
        end
        KIND_SELL: begin
          if (sell_count >= SELL_DEPTH_DEF) begin
            due_q.push_back(lone_result(ST_FULL));
          end else begin
            sell_sym[sell_count]   = sym & SYM_MASK;
            sell_qty[sell_count]   = q;
            sell_price[sell_count] = p;
            sell_count++;
            due_q.push_back(lone_result(ST_ACCEPT));
          end
        end
        KIND_MATCH: walk_book();
        default: ;
      endcase
    endfunction

    task report(string what);
      if (errors < 100) $display("mismatch: result %0d: %s", seen, what);
      errors++;
    endtask

    task check_result(book_result_t got);
      book_result_t want;
      seen++;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result, status %0d", got.status));
        return;
      end
      want = due_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.buy_slot !== want.buy_slot)
        report($sformatf("buy_slot %0d, expected %0d", got.buy_slot, want.buy_slot));
      if (got.sell_slot !== want.sell_slot)
        report($sformatf("sell_slot %0d, expected %0d", got.sell_slot, want.sell_slot));
      if (got.qty !== want.qty)
        report($sformatf("traded_quantity %0d, expected %0d", got.qty, want.qty));
      if (got.psum !== want.psum)
        report($sformatf("price_sum %0d, expected %0d", got.psum, want.psum));
      if (got.last !== want.last)
        report($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask
  endclass

endpackage

// ----- tb/buy_sell_order_matcher_core_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for buy_sell_order_matcher_core: directed and random offers and
// match runs under random idling; depends on bsom_pkg and bsom_tb_pkg
module buy_sell_order_matcher_core_tb;
  import bsom_pkg::*;
  import bsom_tb_pkg::*;

  localparam int RAND_ITEMS   = 105;  // random items that the block acts on
  localparam int QUIET_ITEMS  = 20;   // closing random items sent with no idling
  localparam int HOLD_CYCLES  = 150;  // long receiver hold-off, fills the block up
  localparam int DRAIN_CYCLES = 40;   // settle time after the last expected result

  // a few tickers, zero padded ascii
  localparam logic [SYMIN_W-1:0] SYM_AAA   = 64'h0000_0000_0041_4141;
  localparam logic [SYMIN_W-1:0] SYM_XYZ   = 64'h0000_0000_0058_595A;
  localparam logic [SYMIN_W-1:0] SYM_Q     = 64'h0000_0000_0000_0051;
  // "A", a zero byte, then "B": the byte past the zero still counts
  localparam logic [SYMIN_W-1:0] SYM_SPLIT = 64'h0000_0000_0042_0041;
  localparam logic [SYMIN_W-1:0] SYM_A     = 64'h0000_0000_0000_0041;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cmd_valid;
  logic                 cmd_stall;
  logic [KIND_W-1:0]    kind;
  logic [SYMIN_W-1:0]   symbol;
  logic [QTY_W-1:0]     quantity;
  logic [PRICE_W-1:0]   price_cents;
  logic                 res_valid;
  logic                 res_stall;
  logic [STAT_W-1:0]    status;
  logic [SLOT_W-1:0]    buy_slot;
  logic [SLOT_W-1:0]    sell_slot;
  logic [QTY_W-1:0]     traded_quantity;
  logic [SUM_W-1:0]     price_sum;
  logic                 last;

  order_book_tracker book;
  bit                quiet;     // no idling on either side
  bit                hold_req;  // asks the receiver for one long hold-off
  int                buys_sent;
  int                sells_sent;

  buy_sell_order_matcher_core dut (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_stall       (cmd_stall),
    .kind            (kind),
    .symbol          (symbol),
    .quantity        (quantity),
    .price_cents     (price_cents),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .status          (status),
    .buy_slot        (buy_slot),
    .sell_slot       (sell_slot),
    .traded_quantity (traded_quantity),
    .price_sum       (price_sum),
    .last            (last)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // both channels are sampled at the edge, before any driver update of that edge lands;
  // accepted items feed the order book tracker, accepted results are checked against it
  always @(posedge clk) begin : watch
    book_result_t got;
    if (rst === 1'b0) begin
      if (cmd_valid && !cmd_stall) book.apply_item(kind, symbol, quantity, price_cents);
      if (res_valid && !res_stall) begin
        got = '{status, buy_slot, sell_slot, traded_quantity, price_sum, last};
        book.check_result(got);
      end
    end
  end

  // offer one item and hold it until the block takes it; an idle gap may come first
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [SYMIN_W-1:0] sym,
                           input logic [QTY_W-1:0] q, input logic [PRICE_W-1:0] p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    cmd_valid   <= 1'b1;
    kind        <= k;
    symbol      <= sym;
    quantity    <= q;
    price_cents <= p;
    do @(posedge clk); while (cmd_stall);
    if (k == KIND_BUY) buys_sent++;
    if (k == KIND_SELL) sells_sent++;
  endtask

  // result side: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    res_stall <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin
    int                 n;
    int                 pick;
    logic [KIND_W-1:0]  k;
    logic [SYMIN_W-1:0] sym;
    logic [QTY_W-1:0]   q;
    logic [PRICE_W-1:0] p;
    book        = new();
    quiet       = 1'b0;
    hold_req    = 1'b0;
    buys_sent   = 0;
    sells_sent  = 0;
    rst         <= 1'b1;
    cmd_valid   <= 1'b0;
    kind        <= KIND_BUY;
    symbol      <= '0;
    quantity    <= '0;
    price_cents <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part
    // match on empty tables gives no trades; the unused kind gives nothing at all
    send_item(KIND_MATCH, '0, '0, '0);
    send_item(KIND_UNUSED, SYM_AAA, 16'd7, 24'd7);
    // one buy against three sells: priced out, zero quantity, and a real match
    send_item(KIND_BUY, SYM_AAA, 16'd100, 24'd1000);
    send_item(KIND_SELL, SYM_AAA, 16'd40, 24'd900);
    send_item(KIND_SELL, SYM_AAA, 16'd0, 24'd0);
    send_item(KIND_SELL, SYM_AAA, 16'd100, 24'd1001);
    send_item(KIND_MATCH, '0, '0, '0);
    // quantities stay reduced, so a second run finds nothing
    send_item(KIND_MATCH, '0, '0, '0);
    // split symbol at full quantity and price, and a near miss on the symbol
    send_item(KIND_BUY, SYM_SPLIT, 16'hFFFF, 24'hFF_FFFF);
    send_item(KIND_SELL, SYM_SPLIT, 16'hFFFF, 24'hFF_FFFF);
    send_item(KIND_SELL, SYM_A, 16'd5, 24'd0);
    // all-ones and all-zero symbols with alternating bit patterns
    send_item(KIND_BUY, '1, 16'h5555, 24'hAA_AAAA);
    send_item(KIND_SELL, '1, 16'hAAAA, 24'h55_5555);
    send_item(KIND_BUY, '0, 16'd1, 24'd1);
    send_item(KIND_SELL, '0, 16'd3, 24'd1);
    send_item(KIND_UNUSED, '1, '1, '1);
    send_item(KIND_MATCH, '0, '0, '0);
    send_item(KIND_MATCH, '0, '0, '0);

    // random part, opened by a long result hold-off so that the block backs up
    hold_req = 1'b1;
    n = 0;
    while (n < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) k = KIND_BUY;
      else if (pick < 80) k = KIND_SELL;
      else if (pick < 94) k = KIND_MATCH;
      else k = KIND_UNUSED;
      // small ticker pool so that symbols line up often
      case ($urandom_range(0, 7))
        0, 1, 2: sym = SYM_AAA;
        3, 4:    sym = SYM_XYZ;
        5:       sym = SYM_Q;
        6:       sym = SYM_SPLIT;
        default: sym = {$urandom, $urandom};
      endcase
      if ($urandom_range(0, 9) == 0) q = '0;
      else if ($urandom_range(0, 7) == 0) q = QTY_W'($urandom);
      else q = QTY_W'($urandom_range(1, 300));
      // prices mostly in a narrow band, so buys and sells cross about half the time
      if ($urandom_range(0, 7) == 0) p = PRICE_W'($urandom);
      else p = PRICE_W'($urandom_range(990, 1010));
      quiet = (n >= RAND_ITEMS - QUIET_ITEMS);
      send_item(k, sym, q, p);
      if (k != KIND_UNUSED) n++;
    end

    // top up both tables and go one past, so each side sees a full-table drop
    while (buys_sent <= BUY_DEPTH_DEF) send_item(KIND_BUY, SYM_XYZ, 16'd10, 24'd1010);
    while (sells_sent <= SELL_DEPTH_DEF) send_item(KIND_SELL, SYM_XYZ, 16'd15, 24'd990);
    send_item(KIND_MATCH, '0, '0, '0);
    cmd_valid <= 1'b0;
    // let the watcher note the last item before the expected results are counted
    @(posedge clk);

    // drain, then give the block time to show any stray result
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0) begin
      $display("buy_sell_order_matcher_core_tb: done, clean");
    end else begin
      $display("buy_sell_order_matcher_core_tb: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("buy_sell_order_matcher_core_tb: done, errors");
    $finish;
  end

endmodule
